/* rtl/core/partial_sum_aggregation_table_macros.svh */
// Assertion macros shared by the partial-sum aggregation table modules.
// Each macro expects a clock named clk and an active-high reset named rst in scope.
`ifndef PARTIAL_SUM_AGGREGATION_TABLE_MACROS_SVH
`define PARTIAL_SUM_AGGREGATION_TABLE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSAT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/psat_pkg.sv */
// Shared types and constants for the partial-sum aggregation table.
// No dependencies; imported by every module of the block.
`default_nettype none

package psat_pkg;

  localparam int TAG_W     = 8;
  localparam int VAL_IN_W  = 32;
  localparam int TOTAL_W   = 8;
  localparam int SUM_W     = 48;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 64;

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_DROPPED  = 2'd2
  } psat_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_LOOKUP,
    BK_UPDATE
  } psat_back_state_t;

  // One queued word: tag already masked, value already sign-extended.
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SUM_W-1:0]   value;
    logic [TOTAL_W-1:0] total;
  } psat_item_t;

  typedef struct packed {
    psat_status_t       status;
    logic [SUM_W-1:0]   sum;
    logic [TAG_W-1:0]   tag;
  } psat_result_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [TOTAL_W-1:0] done;
    logic [TOTAL_W-1:0] total;
  } psat_entry_t;

endpackage

`default_nettype wire

/* rtl/core/partial_sum_aggregation_table.sv */
// Partial-sum aggregation table. Each accepted word is one partial result of a
// tagged request and yields exactly one result word, in order: pending,
// complete with the 48-bit wrapped sum, or dropped when a new tag finds every
// entry busy. A two-word input queue and a one-word output register decouple
// both sides. Each word passes from the queue through the tag lookup and then
// the read-modify-write of the entry memory into the output register; the next
// word is taken only as the current one is written out. The entry table needs
// no clearing pass after reset.
// Depends on psat_pkg, psat_front and psat_back.
`default_nettype none

module partial_sum_aggregation_table
  import psat_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int VALUE_WIDTH   = 32,
  parameter int TAG_WIDTH     = 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // request_tag [7:0], partial_value [39:8], total_parts [47:40]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // status [1:0], aggregated_sum [49:2], result_tag [57:50], zero [63:58]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata
);

  logic         q_valid;
  psat_item_t   q_item;
  logic         q_pop;
  psat_result_t out_res;

  psat_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .TAG_WIDTH   (TAG_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  psat_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .TAG_WIDTH     (TAG_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_res   (out_res),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-2-SUM_W-TAG_W){1'b0}}, out_res.tag, out_res.sum,
                         out_res.status};

endmodule

`default_nettype wire

/* rtl/core/psat_front.sv */
// Input side of the aggregation table: unpacks, masks and widens each word
// and holds it in a two-word queue. Depends on psat_pkg and the macros header.
`default_nettype none

`include "partial_sum_aggregation_table_macros.svh"

module psat_front
  import psat_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int TAG_WIDTH   = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // request_tag [7:0], partial_value [39:8], total_parts [47:40]
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,
  output logic                      q_valid,
  output psat_item_t                q_item,
  input  wire logic                 q_pop
);

  localparam int MatchW = (TAG_WIDTH < TAG_W) ? TAG_WIDTH : TAG_W;
  localparam logic [TAG_W-1:0] TagMask = {TAG_W{1'b1}} >> (TAG_W - MatchW);
  localparam logic [SUM_W-1:0] ValMask = {SUM_W{1'b1}} >> (SUM_W - VALUE_WIDTH);

  logic [TAG_W-1:0]    in_tag;
  logic [VAL_IN_W-1:0] in_val;
  logic [TOTAL_W-1:0]  in_total;
  logic [SUM_W-1:0]    raw_val;
  logic [SUM_W-1:0]    masked_val;
  psat_item_t          item_in;
  psat_item_t          slots [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;
  logic                push;

  assign in_tag   = s_axis_tdata[TAG_W-1:0];
  assign in_val   = s_axis_tdata[TAG_W +: VAL_IN_W];
  assign in_total = s_axis_tdata[TAG_W+VAL_IN_W +: TOTAL_W];

  assign raw_val    = {{(SUM_W-VAL_IN_W){1'b0}}, in_val};
  assign masked_val = raw_val & ValMask;

  always_comb begin
    item_in.tag   = in_tag & TagMask;
    item_in.value = raw_val[VALUE_WIDTH-1] ? (masked_val | ~ValMask) : masked_val;
    item_in.total = in_total;
  end

  assign s_axis_tready = (count != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != 2'd0);
  assign q_item        = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  `PSAT_ASSERT_IMPL(a_pop_nonempty, q_pop, count != 2'd0, "queue popped while empty")
  `PSAT_ASSERT_IMPL(a_count_bound, 1'b1, count != 2'd3, "queue count beyond depth")

endmodule

`default_nettype wire

/* rtl/core/psat_back.sv */
// Table side of the aggregation block: tag match, entry read-modify-write and
// the output register. Depends on psat_pkg and the macros header.
`default_nettype none

`include "partial_sum_aggregation_table_macros.svh"

module psat_back
  import psat_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16,
  parameter int TAG_WIDTH     = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire psat_item_t  q_item,
  output logic             q_pop,
  output logic             out_valid,
  output psat_result_t     out_res,
  input  wire logic        out_ready
);

  localparam int IdxW   = $clog2(TABLE_ENTRIES);
  localparam int MatchW = (TAG_WIDTH < TAG_W) ? TAG_WIDTH : TAG_W;

  psat_back_state_t         state;
  psat_back_state_t         state_next;
  psat_item_t               cur;
  logic [TABLE_ENTRIES-1:0] entry_valid;
  logic [MatchW-1:0]        entry_tag [TABLE_ENTRIES];
  psat_entry_t              entry_mem [TABLE_ENTRIES];
  psat_entry_t              rd_entry;

  logic [TABLE_ENTRIES-1:0] match;
  logic                     lk_hit;
  logic [IdxW-1:0]          lk_hit_idx;
  logic                     lk_free;
  logic [IdxW-1:0]          lk_free_idx;

  logic                     hit;
  logic [IdxW-1:0]          hit_idx;
  logic                     free_ok;
  logic [IdxW-1:0]          free_idx;

  logic [SUM_W-1:0]         new_sum;
  logic [TOTAL_W-1:0]       new_done;
  logic                     done_all;
  logic                     single;
  logic                     alloc;
  logic                     advance;
  psat_result_t             res_next;

  // Match against every live entry; at most one can carry a given tag.
  always_comb begin
    match       = '0;
    lk_hit_idx  = '0;
    lk_free     = 1'b0;
    lk_free_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = entry_valid[i] && (entry_tag[i] == cur.tag[MatchW-1:0]);
      if (match[i]) begin
        lk_hit_idx = lk_hit_idx | IdxW'(i);
      end
    end
    // lowest free entry wins
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!entry_valid[i]) begin
        lk_free     = 1'b1;
        lk_free_idx = IdxW'(i);
      end
    end
    lk_hit = |match;
  end

  assign new_sum  = rd_entry.sum + cur.value;
  assign new_done = rd_entry.done + 8'd1;
  assign done_all = (new_done >= rd_entry.total);
  assign single   = (cur.total <= 8'd1);
  assign alloc    = !hit && !single && free_ok;
  assign advance  = (state == BK_UPDATE) && (!out_valid || out_ready);

  always_comb begin
    res_next.tag    = cur.tag;
    res_next.sum    = '0;
    res_next.status = ST_PENDING;
    if (hit) begin
      if (done_all) begin
        res_next.status = ST_COMPLETE;
        res_next.sum    = new_sum;
      end
    end else if (single) begin
      res_next.status = ST_COMPLETE;
      res_next.sum    = cur.value;
    end else if (!free_ok) begin
      res_next.status = ST_DROPPED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = BK_LOOKUP;
        end
      end
      BK_LOOKUP: begin
        state_next = BK_UPDATE;
      end
      BK_UPDATE: begin
        if (advance) begin
          // take the next word straight away when one is queued
          if (q_valid) begin
            q_pop      = 1'b1;
            state_next = BK_LOOKUP;
          end else begin
            state_next = BK_IDLE;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (state == BK_LOOKUP) begin
      hit      <= lk_hit;
      hit_idx  <= lk_hit_idx;
      free_ok  <= lk_free;
      free_idx <= lk_free_idx;
      rd_entry <= entry_mem[lk_hit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (advance) begin
      if (hit && done_all) begin
        entry_valid[hit_idx] <= 1'b0;
      end else if (alloc) begin
        entry_valid[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (hit) begin
        entry_mem[hit_idx] <= '{sum: new_sum, done: new_done, total: rd_entry.total};
      end else if (alloc) begin
        entry_mem[free_idx] <= '{sum: cur.value, done: 8'd1, total: cur.total};
        entry_tag[free_idx] <= cur.tag[MatchW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res_next;
    end
  end

  `PSAT_ASSERT_IMPL(a_tag_unique, state == BK_LOOKUP, $onehot0(match),
                    "tag held in two entries")
  `PSAT_ASSERT_IMPL(a_drop_when_full, advance && (res_next.status == ST_DROPPED),
                    &entry_valid, "word dropped with a free entry")
  `PSAT_ASSERT_NEXT(a_complete_frees, advance && hit && done_all,
                    !entry_valid[$past(hit_idx)], "completed entry not freed")

endmodule

`default_nettype wire
